FILE: rtl/escp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_pkg: shared types and token codes
// Request and result payloads, token kinds and the decoded command record
// that travels from the front decoder to the token sequencer.
// ----------------------------------------------------------------------------
package escp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 14;
    localparam int TOKENS  = 3;
    localparam int COUNT_W = 2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_CHAR       = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TAB        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SPACE      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ENTITY     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PARA       = 4'd4;
    localparam logic [KIND_W-1:0] KIND_CLOSE_PARA = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OPEN_T1    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_OPEN_T2    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CLOSE_SPAN = 4'd8;
    localparam logic [KIND_W-1:0] KIND_STYLE_HEAD = 4'd9;
    localparam logic [KIND_W-1:0] KIND_STOP       = 4'd10;
    localparam logic [KIND_W-1:0] KIND_STYLE_TAIL = 4'd11;
    localparam logic [KIND_W-1:0] KIND_PARA_SW    = 4'd12;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } token_t;

    // one decoded request: 1 to 3 tokens, slot 0 goes out first
    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        token_t [TOKENS-1:0]    tok;
    } cmd_t;

endpackage

FILE: rtl/escp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_front: stream decoder
// Tracks the parser state and turns each accepted byte into a command of up
// to three tokens.
// ----------------------------------------------------------------------------
module escp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  escp_pkg::item_t item,
    output logic            cmd_push,
    output escp_pkg::cmd_t  cmd
);
    import escp_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_ARG    = 2'd2;
    localparam logic [1:0] MODE_TABS   = 2'd3;

    localparam logic [BYTE_W-1:0] CODE_ESC = 8'd27;
    localparam logic [BYTE_W-1:0] CODE_TABDEF = 8'd68;

    logic [1:0]        mode_reg, mode_next;
    logic              dbl_reg, dbl_next;
    logic              cond_reg, cond_next;
    logic [7:0]        style_reg, style_next;
    logic              lwz_reg, lwz_next;
    logic [2:0]        zr_reg, zr_next;
    logic              halted_reg, halted_next;

    logic [BYTE_W-1:0]  b;
    logic [COUNT_W-1:0] n;
    logic               do_track;
    logic [7:0]         sc_inc;
    logic [VALUE_W-1:0] sc1, sc2, sc_inc1, tab_pos;

    function automatic token_t mk_tok(input logic [KIND_W-1:0] k,
                                      input logic [VALUE_W-1:0] v);
        token_t t;
        t.kind  = k;
        t.value = v;
        return t;
    endfunction

    // last UTF-8 byte of a box-drawing character
    function automatic logic [VALUE_W-1:0] box_third(input logic [BYTE_W-1:0] c);
        logic [VALUE_W-1:0] r;
        case (c)
            8'd218:  r = 14'd140;
            8'd196:  r = 14'd128;
            8'd191:  r = 14'd144;
            8'd179:  r = 14'd130;
            8'd192:  r = 14'd148;
            8'd217:  r = 14'd152;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

    assign b       = item.byte_in;
    assign sc1     = {6'd0, style_reg} + 14'd1;
    assign sc2     = {6'd0, style_reg} + 14'd2;
    assign sc_inc  = (style_reg == 8'hFF) ? style_reg : style_reg + 8'd1;
    assign sc_inc1 = {6'd0, sc_inc} + 14'd1;
    assign tab_pos = {6'd0, b} * 14'd54;

    always_comb
    begin
        mode_next   = mode_reg;
        dbl_next    = dbl_reg;
        cond_next   = cond_reg;
        style_next  = style_reg;
        lwz_next    = lwz_reg;
        zr_next     = zr_reg;
        halted_next = halted_reg;
        cmd         = '0;
        n           = 2'd0;
        do_track    = 1'b0;

        if (!halted_reg)
        begin
            case (mode_reg)
                MODE_NORMAL:
                begin
                    if (b == CODE_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        do_track = 1'b1;
                        case (b)
                            8'd9:
                            begin
                                cmd.tok[0] = mk_tok(KIND_TAB, 14'd0);
                                n = 2'd1;
                            end
                            8'd10:
                            begin
                                cmd.tok[0] = mk_tok(dbl_reg ? KIND_CLOSE_PARA : KIND_PARA, sc1);
                                dbl_next = 1'b0;
                                n = 2'd1;
                            end
                            8'd14:
                            begin
                                cmd.tok[0] = mk_tok(KIND_OPEN_T1, 14'd0);
                                dbl_next = 1'b1;
                                n = 2'd1;
                            end
                            8'd15:
                            begin
                                cmd.tok[0] = mk_tok(KIND_OPEN_T2, 14'd0);
                                cond_next = 1'b1;
                                n = 2'd1;
                            end
                            8'd18:
                            begin
                                if (cond_reg)
                                begin
                                    cmd.tok[0] = mk_tok(KIND_CLOSE_SPAN, 14'd0);
                                    cond_next = 1'b0;
                                    n = 2'd1;
                                end
                            end
                            8'd20:
                            begin
                                cmd.tok[0] = mk_tok(KIND_CLOSE_SPAN, 14'd0);
                                dbl_next = 1'b0;
                                n = 2'd1;
                            end
                            8'd39:
                            begin
                                cmd.tok[0] = mk_tok(KIND_ENTITY, 14'd0);
                                n = 2'd1;
                            end
                            8'd34:
                            begin
                                cmd.tok[0] = mk_tok(KIND_ENTITY, 14'd1);
                                n = 2'd1;
                            end
                            8'd60:
                            begin
                                cmd.tok[0] = mk_tok(KIND_ENTITY, 14'd2);
                                n = 2'd1;
                            end
                            8'd62:
                            begin
                                cmd.tok[0] = mk_tok(KIND_ENTITY, 14'd3);
                                n = 2'd1;
                            end
                            8'd218, 8'd196, 8'd191, 8'd179, 8'd192, 8'd217:
                            begin
                                cmd.tok[0] = mk_tok(KIND_CHAR, 14'd226);
                                cmd.tok[1] = mk_tok(KIND_CHAR, 14'd148);
                                cmd.tok[2] = mk_tok(KIND_CHAR, box_third(b));
                                n = 2'd3;
                            end
                            8'd248:
                            begin
                                cmd.tok[0] = mk_tok(KIND_CHAR, 14'd194);
                                cmd.tok[1] = mk_tok(KIND_CHAR, 14'd176);
                                n = 2'd2;
                            end
                            8'd130:
                            begin
                                cmd.tok[0] = mk_tok(KIND_CHAR, 14'd195);
                                cmd.tok[1] = mk_tok(KIND_CHAR, 14'd169);
                                n = 2'd2;
                            end
                            default:
                            begin
                                if (b == 8'd32)
                                begin
                                    cmd.tok[0] = mk_tok(KIND_SPACE, 14'd0);
                                    n = 2'd1;
                                end
                                else if (b > 8'd32 && b <= 8'd125)
                                begin
                                    cmd.tok[0] = mk_tok(KIND_CHAR, {6'd0, b});
                                    n = 2'd1;
                                end
                            end
                        endcase
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_NORMAL;
                    if (b == 8'd14)
                    begin
                        cmd.tok[0] = mk_tok(KIND_OPEN_T1, 14'd0);
                        dbl_next = 1'b1;
                        n = 2'd1;
                        do_track = 1'b1;
                    end
                    else if (b == 8'd15)
                    begin
                        cmd.tok[0] = mk_tok(KIND_OPEN_T2, 14'd0);
                        cond_next = 1'b1;
                        n = 2'd1;
                        do_track = 1'b1;
                    end
                    else if (b == 8'd45 || b == 8'd85 || b == 8'd87 || b == 8'd83)
                    begin
                        mode_next = MODE_ARG;
                    end
                    else if (b == CODE_TABDEF)
                    begin
                        cmd.tok[0] = mk_tok(KIND_STYLE_HEAD, sc2);
                        n = 2'd1;
                        mode_next = MODE_TABS;
                    end
                    else
                    begin
                        do_track = 1'b1;
                    end
                end
                MODE_ARG:
                begin
                    mode_next = MODE_NORMAL;
                    do_track  = 1'b1;
                end
                default:
                begin
                    if (b != 8'd0)
                    begin
                        cmd.tok[0] = mk_tok(KIND_STOP, tab_pos);
                        n = 2'd1;
                    end
                    else
                    begin
                        cmd.tok[0] = mk_tok(KIND_STYLE_TAIL, 14'd0);
                        cmd.tok[1] = mk_tok(KIND_PARA_SW, sc_inc1);
                        n = 2'd2;
                        style_next = sc_inc;
                        mode_next = MODE_NORMAL;
                        do_track = 1'b1;
                    end
                end
            endcase
        end

        // zero-run tracking, five zero items in a row stop the job
        if (do_track)
        begin
            if (b == 8'd0)
            begin
                if (lwz_reg && zr_reg != 3'd7)
                begin
                    zr_next = zr_reg + 3'd1;
                end
                lwz_next = 1'b1;
                if (zr_next >= 3'd4)
                begin
                    halted_next = 1'b1;
                end
            end
            else
            begin
                lwz_next = 1'b0;
                zr_next  = 3'd0;
            end
        end

        if (item.last)
        begin
            mode_next   = MODE_NORMAL;
            dbl_next    = 1'b0;
            cond_next   = 1'b0;
            style_next  = 8'd0;
            lwz_next    = 1'b0;
            zr_next     = 3'd0;
            halted_next = 1'b0;
        end

        cmd.count = n;
    end

    assign cmd_push = take && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            dbl_reg    <= 1'b0;
            cond_reg   <= 1'b0;
            style_reg  <= 8'd0;
            lwz_reg    <= 1'b0;
            zr_reg     <= 3'd0;
            halted_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            dbl_reg    <= dbl_next;
            cond_reg   <= cond_next;
            style_reg  <= style_next;
            lwz_reg    <= lwz_next;
            zr_reg     <= zr_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: rtl/escp_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_cmd_fifo: two-entry command queue
// Decouples the decoder from the token sequencer.
// ----------------------------------------------------------------------------
module escp_cmd_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  escp_pkg::cmd_t wr_data,
    input  logic           rd,
    output escp_pkg::cmd_t rd_data,
    output logic           not_empty,
    output logic           full
);
    import escp_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/escp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_back: token sequencer
// Plays out the tokens of each queued command into the result register,
// one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module escp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  escp_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output escp_pkg::result_t result
);
    import escp_pkg::*;

    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               slot_free;
    logic               is_last;

    assign slot_free = !out_valid_reg || pop;
    assign is_last   = (idx_reg == q_cmd.count - 2'd1);
    assign q_pop     = q_valid && slot_free && is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (q_valid && slot_free)
        begin
            out_next.kind        = q_cmd.tok[idx_reg].kind;
            out_next.value       = q_cmd.tok[idx_reg].value;
            out_next.last_result = is_last;
            out_valid_next       = 1'b1;
            idx_next             = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

FILE: rtl/escp_stream_to_layout_tokens_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_stream_to_layout_tokens_unit: ESC/P byte stream to layout tokens
// Top level: decoder, command queue and token sequencer.
// ----------------------------------------------------------------------------
// Push one printer byte per request. The unit answers with zero to three
// layout tokens, oldest first, on the result port. A byte is taken when
// push is high and the command queue has room, and the next one may follow
// at once. On an idle path the first token of a byte passes through the
// command queue and then the result register before it shows on the result
// port. Tokens leave one per cycle through the single result register while
// the result side pops. A byte holds the sequencer until all of its tokens
// have gone into the result register. Bytes with no tokens never enter the
// queue. The command queue between decoder and sequencer holds two decoded
// bytes. Full rises when the result side stalls. It also rises when
// bytes with two or three tokens come back to back faster than the
// sequencer can play them out: two three-token bytes in a row fill the
// queue, and the next byte waits until the first of them has played out.
// last_result marks the final token that a byte produced. When last is set
// on a byte, the parser returns to its reset state once that byte is
// decoded. There is no clearing pass after reset: the unit takes requests
// as soon as reset is released.
// ----------------------------------------------------------------------------
module escp_stream_to_layout_tokens_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  escp_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output escp_pkg::result_t result
);
    import escp_pkg::*;

    logic take;
    logic cmd_push;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_valid;
    logic q_pop;
    logic q_full;

    // a request is taken whenever the command queue has room
    assign full = q_full;
    assign take = push && !q_full;

    // front: parser state and byte classification
    escp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // queue of decoded commands, only bytes that yield tokens enter it
    escp_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (cmd_push),
        .wr_data   (front_cmd),
        .rd        (q_pop),
        .rd_data   (head_cmd),
        .not_empty (q_valid),
        .full      (q_full)
    );

    // back: one token per cycle into the result register while it is free
    escp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

FILE: rtl/escp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escp_checker: port-level checks
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module escp_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input escp_pkg::result_t result
);
    import escp_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    // the queue only fills behind a loaded result register
    a_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full with no result showing");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind <= KIND_PARA_SW))
        else $error("token kind out of range");

    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.kind == KIND_TAB || result.kind == KIND_SPACE ||
                    result.kind == KIND_OPEN_T1 || result.kind == KIND_OPEN_T2 ||
                    result.kind == KIND_CLOSE_SPAN || result.kind == KIND_STYLE_TAIL))
        |-> (result.value == '0))
        else $error("nonzero value on a valueless token");

endmodule

bind escp_stream_to_layout_tokens_unit escp_checker u_escp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: dv/tb_escp_stream_to_layout_tokens_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escp_stream_to_layout_tokens_unit: self-checking bench for the ESC/P token unit
// Pushes printer bytes as requests and predicts the layout tokens each one
// should produce. A scoreboard compares every popped token field by field.
// Directed bytes come first, then a short run of tab-stop styles, then
// random phrases. Both queue sides idle at random until the quiet tail.
// ----------------------------------------------------------------------------
module tb_escp_stream_to_layout_tokens_unit;

    import escp_pkg::*;

    // control and escape bytes of the printer stream
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SO    = 8'd14;   // one-line double width
    localparam logic [7:0] CH_SI    = 8'd15;   // condensed
    localparam logic [7:0] CH_DC2   = 8'd18;   // condensed off
    localparam logic [7:0] CH_DC4   = 8'd20;   // double width off
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOT  = 8'd34;
    localparam logic [7:0] CH_APOS  = 8'd39;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_FIRST = 8'd33;   // printable pass-through range
    localparam logic [7:0] CH_LAST  = 8'd125;

    // ESC sub-commands that take one argument byte, and ESC D (tab stops)
    localparam logic [7:0] ESC_UNDERLINE = 8'd45;
    localparam logic [7:0] ESC_UNIDIR    = 8'd85;
    localparam logic [7:0] ESC_WIDE      = 8'd87;
    localparam logic [7:0] ESC_SCRIPT    = 8'd83;
    localparam logic [7:0] ESC_TABSTOPS  = 8'd68;

    // code-page bytes that expand to UTF-8
    localparam logic [7:0] BOX_DOWN_RIGHT = 8'd218;
    localparam logic [7:0] BOX_HORIZ      = 8'd196;
    localparam logic [7:0] BOX_DOWN_LEFT  = 8'd191;
    localparam logic [7:0] BOX_VERT       = 8'd179;
    localparam logic [7:0] BOX_UP_RIGHT   = 8'd192;
    localparam logic [7:0] BOX_UP_LEFT    = 8'd217;
    localparam logic [7:0] CP_DEGREE      = 8'd248;
    localparam logic [7:0] CP_E_ACUTE     = 8'd130;

    // entity numbers carried in the value field
    localparam int ENT_APOS = 0;
    localparam int ENT_QUOT = 1;
    localparam int ENT_LT   = 2;
    localparam int ENT_GT   = 3;

    localparam int STOP_SCALE = 54;   // tenths of a point per stop unit
    localparam int ZERO_HALT  = 4;    // zero_run value that stops the job

    localparam logic [7:0] OPENING_BYTES [23] = '{
        CH_LAST, CH_SPACE, CH_TAB, CH_APOS, CH_QUOT, CH_LT, CH_GT,
        BOX_DOWN_RIGHT, BOX_HORIZ, BOX_DOWN_LEFT, BOX_VERT, BOX_UP_RIGHT, BOX_UP_LEFT,
        CP_DEGREE, CP_E_ACUTE,
        CH_DC2, CH_SI, CH_DC2, CH_SO, CH_LF, CH_LF, CH_DC4, 8'd255
    };

    localparam logic [7:0] SPECIAL_BYTES [15] = '{
        CH_TAB, CH_LF, CH_SO, CH_SI, CH_DC2, CH_DC4, CH_SPACE,
        BOX_DOWN_RIGHT, BOX_HORIZ, BOX_DOWN_LEFT, BOX_VERT, BOX_UP_RIGHT, BOX_UP_LEFT,
        CP_DEGREE, CP_E_ACUTE
    };

    localparam logic [7:0] ESC_SUBS [7] = '{
        CH_SO, CH_SI, ESC_UNDERLINE, ESC_UNIDIR, ESC_WIDE, ESC_SCRIPT, ESC_TABSTOPS
    };

    typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_ARG, PM_TABS} parse_mode_e;

    // ------------------------------------------------------------------------
    // Token scoreboard: own copy of the parser state, a queue of predicted
    // tokens, and the compare against what the unit pops.
    // ------------------------------------------------------------------------
    class layout_token_scoreboard;
        result_t     expected_tokens[$];
        result_t     burst[$];          // tokens of the request being decoded
        int          mismatches;
        parse_mode_e mode;
        bit          double_line;
        bit          condensed_on;
        bit [7:0]    style_count;
        bit          last_was_zero;
        bit [2:0]    zero_run;
        bit          halted;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode          = PM_NORMAL;
            double_line   = 1'b0;
            condensed_on  = 1'b0;
            style_count   = '0;
            last_was_zero = 1'b0;
            zero_run      = '0;
            halted        = 1'b0;
        endfunction

        function void add_token(logic [KIND_W-1:0] kind, int unsigned value);
            result_t tok;
            tok.kind        = kind;
            tok.value       = VALUE_W'(value);
            tok.last_result = 1'b0;
            if (burst.size() < TOKENS)
                burst.push_back(tok);
        endfunction

        function void add_box(int unsigned third);
            add_token(KIND_CHAR, 226);
            add_token(KIND_CHAR, 148);
            add_token(KIND_CHAR, third);
        endfunction

        // only bytes that complete an item move the zero tracking
        function void count_zero(logic [7:0] b);
            if (b == CH_NUL) begin
                if (last_was_zero && zero_run < 3'd7)
                    zero_run++;
                last_was_zero = 1'b1;
                if (zero_run >= ZERO_HALT)
                    halted = 1'b1;
            end
            else begin
                last_was_zero = 1'b0;
                zero_run      = '0;
            end
        endfunction

        // predict the tokens of one accepted request
        function void decode_byte(item_t req);
            logic [7:0] b;
            b = req.byte_in;
            burst.delete();
            if (!halted) begin
                case (mode)
                    PM_NORMAL: begin
                        if (b == CH_ESC)
                            mode = PM_ESC;
                        else begin
                            case (b)
                                CH_TAB: add_token(KIND_TAB, 0);
                                CH_LF: begin
                                    if (double_line) begin
                                        add_token(KIND_CLOSE_PARA, style_count + 1);
                                        double_line = 1'b0;
                                    end
                                    else
                                        add_token(KIND_PARA, style_count + 1);
                                end
                                CH_SO: begin
                                    add_token(KIND_OPEN_T1, 0);
                                    double_line = 1'b1;
                                end
                                CH_SI: begin
                                    add_token(KIND_OPEN_T2, 0);
                                    condensed_on = 1'b1;
                                end
                                CH_DC2: begin
                                    if (condensed_on) begin
                                        condensed_on = 1'b0;
                                        add_token(KIND_CLOSE_SPAN, 0);
                                    end
                                end
                                CH_DC4: begin
                                    add_token(KIND_CLOSE_SPAN, 0);
                                    double_line = 1'b0;
                                end
                                CH_APOS:        add_token(KIND_ENTITY, ENT_APOS);
                                CH_QUOT:        add_token(KIND_ENTITY, ENT_QUOT);
                                CH_LT:          add_token(KIND_ENTITY, ENT_LT);
                                CH_GT:          add_token(KIND_ENTITY, ENT_GT);
                                BOX_DOWN_RIGHT: add_box(140);
                                BOX_HORIZ:      add_box(128);
                                BOX_DOWN_LEFT:  add_box(144);
                                BOX_VERT:       add_box(130);
                                BOX_UP_RIGHT:   add_box(148);
                                BOX_UP_LEFT:    add_box(152);
                                CP_DEGREE: begin
                                    add_token(KIND_CHAR, 194);
                                    add_token(KIND_CHAR, 176);
                                end
                                CP_E_ACUTE: begin
                                    add_token(KIND_CHAR, 195);
                                    add_token(KIND_CHAR, 169);
                                end
                                default: begin
                                    if (b == CH_SPACE)
                                        add_token(KIND_SPACE, 0);
                                    else if (b >= CH_FIRST && b <= CH_LAST)
                                        add_token(KIND_CHAR, b);
                                end
                            endcase
                            count_zero(b);
                        end
                    end
                    PM_ESC: begin
                        mode = PM_NORMAL;
                        if (b == CH_SO) begin
                            add_token(KIND_OPEN_T1, 0);
                            double_line = 1'b1;
                            count_zero(b);
                        end
                        else if (b == CH_SI) begin
                            add_token(KIND_OPEN_T2, 0);
                            condensed_on = 1'b1;
                            count_zero(b);
                        end
                        else if (b inside {ESC_UNDERLINE, ESC_UNIDIR, ESC_WIDE, ESC_SCRIPT})
                            mode = PM_ARG;
                        else if (b == ESC_TABSTOPS) begin
                            add_token(KIND_STYLE_HEAD, style_count + 2);
                            mode = PM_TABS;
                        end
                        else
                            count_zero(b);
                    end
                    PM_ARG: begin
                        mode = PM_NORMAL;
                        count_zero(b);
                    end
                    default: begin
                        if (b != CH_NUL)
                            add_token(KIND_STOP, b * STOP_SCALE);
                        else begin
                            add_token(KIND_STYLE_TAIL, 0);
                            if (style_count != 8'd255)
                                style_count++;
                            add_token(KIND_PARA_SW, style_count + 1);
                            mode = PM_NORMAL;
                            count_zero(b);
                        end
                    end
                endcase
            end
            if (burst.size() > 0)
                burst[burst.size() - 1].last_result = 1'b1;
            foreach (burst[i])
                expected_tokens.push_back(burst[i]);
            if (req.last)
                clear_state();
        endfunction

        function void check_token(result_t got);
            result_t want;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token, expected none, actual kind %0d value %0d",
                         $time, got.kind, got.value);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: kind mismatch, expected %0d, actual %0d",
                         $time, want.kind, got.kind);
                mismatches++;
            end
            if (got.value !== want.value) begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, want.value, got.value);
                mismatches++;
            end
            if (got.last_result !== want.last_result) begin
                $display("%0t: last_result mismatch, expected %0d, actual %0d",
                         $time, want.last_result, got.last_result);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the unit
    // ------------------------------------------------------------------------
    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    bit          quiet = 1'b0;   // no idling on either side when set
    int unsigned sent  = 0;      // accepted requests so far
    int unsigned pop_hold = 0;

    layout_token_scoreboard sb;

    always #5 clk = ~clk;

    escp_stream_to_layout_tokens_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Both handshakes are sampled here, at the edge itself, before any of
    // this edge's nonblocking updates land. The request is noted first; its
    // tokens cannot leave at the same edge.
    always @(posedge clk) begin
        if (rst_n && push && !full)
            sb.decode_byte(item);
        if (rst_n && pop && !empty)
            sb.check_token(result);
    end

    // Result side: pop is held low in bursts of random length.
    always @(posedge clk) begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold != 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop_hold <= $urandom_range(0, 10);
            pop      <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // One request. push stays high between back-to-back requests so it never
    // gets two updates in one step; it only drops for an idle burst.
    task automatic send_request(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push         <= 1'b1;
        item.byte_in <= b;
        item.last    <= fin;
        do @(posedge clk); while (full);
        sent++;
    endtask

    // Stop sending and let every predicted token come out.
    task automatic wait_for_tokens();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed phrases with random content; the rest is loose
    // bytes, jobs cut short and zero runs that halt the job.
    task automatic send_random_phrase();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  sub;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: send_request(8'($urandom_range(CH_FIRST, CH_LAST)), 1'b0);
            3: send_request(SPECIAL_BYTES[$urandom_range(0, 14)], 1'b0);
            4: begin
                send_request(CH_ESC, 1'b0);
                sub = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : ESC_SUBS[$urandom_range(0, 5)];
                send_request(sub, 1'b0);
                if (sub inside {ESC_UNDERLINE, ESC_UNIDIR, ESC_WIDE, ESC_SCRIPT})
                    send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            5: begin
                // tab-stop style: ESC D, a few stops, closing zero
                send_request(CH_ESC, 1'b0);
                send_request(ESC_TABSTOPS, 1'b0);
                n = $urandom_range(0, 4);
                repeat (n) send_request(8'($urandom_range(1, 255)), 1'b0);
                send_request(CH_NUL, 1'b0);
            end
            6: begin
                n = $urandom_range(1, 6);
                repeat (n) send_request(CH_NUL, 1'b0);
                // a halted job is ignored until its last byte
                if (n >= 5) begin
                    send_request(8'($urandom_range(0, 255)), 1'b0);
                    send_request(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            7: send_request(8'($urandom_range(0, 255)), 1'b0);
            8: send_request(8'($urandom_range(0, 255)), 1'b1);
            default: begin
                // job ends inside an escape or a stop list
                send_request(CH_ESC, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_request(ESC_TABSTOPS, 1'b0);
                    send_request(8'($urandom_range(1, 255)), 1'b0);
                end
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned start;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every plain byte operation, both states of DC2, LF with and
        // without double width, and an unknown high byte
        foreach (OPENING_BYTES[i])
            send_request(OPENING_BYTES[i], 1'b0);
        // condensed through ESC SI
        send_request(CH_ESC, 1'b0);
        send_request(CH_SI, 1'b0);
        // argument byte swallowed (a zero argument still counts as zero)
        send_request(CH_ESC, 1'b0);
        send_request(ESC_UNIDIR, 1'b0);
        send_request(CH_NUL, 1'b0);
        // largest stop value, then the closing zero
        send_request(CH_ESC, 1'b0);
        send_request(ESC_TABSTOPS, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(CH_NUL, 1'b0);
        // stop list still open at end of job
        send_request(CH_ESC, 1'b0);
        send_request(ESC_TABSTOPS, 1'b0);
        send_request(8'd1, 1'b1);
        // five zeros halt; the rest is ignored up to the last byte
        repeat (5) send_request(CH_NUL, 1'b0);
        send_request(8'd65, 1'b0);
        send_request(8'd65, 1'b1);

        // sender holds off until the unit has drained
        wait_for_tokens();

        // a few styles in a row; a printable byte between styles keeps the
        // closing zeros from halting the job
        repeat (3) begin
            send_request(CH_ESC, 1'b0);
            send_request(ESC_TABSTOPS, 1'b0);
            send_request(8'($urandom_range(1, 255)), 1'b0);
            send_request(CH_NUL, 1'b0);
            send_request(8'($urandom_range(CH_FIRST, CH_LAST)), 1'b0);
        end
        send_request(CH_LF, 1'b0);
        send_request(CH_ESC, 1'b0);
        send_request(ESC_TABSTOPS, 1'b0);
        send_request(CH_NUL, 1'b0);
        send_request(8'd65, 1'b1);
        wait_for_tokens();

        // random phrases; the last quarter runs without idling
        start = sent;
        while (sent - start < 40) begin
            quiet = (sent - start >= 30);
            send_random_phrase();
        end
        quiet = 1'b1;

        wait_for_tokens();
        repeat (16) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
